/* sv/jsv_pkg.sv */
`default_nettype none

package jsv_pkg;

    typedef enum logic [3:0] {
        PH_LEAD      = 4'd0,
        PH_LIT_TRUE  = 4'd1,
        PH_LIT_FALSE = 4'd2,
        PH_LIT_NULL  = 4'd3,
        PH_MINUS     = 4'd4,
        PH_ZERO      = 4'd5,
        PH_INT       = 4'd6,
        PH_DOT       = 4'd7,
        PH_FRAC      = 4'd8,
        PH_EXP       = 4'd9,
        PH_EXP_SIGN  = 4'd10,
        PH_EXP_DIG   = 4'd11,
        PH_TRAIL     = 4'd12,
        PH_ERROR     = 4'd13
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_EXPECT       = 2'd1,
        ST_INVALID      = 2'd2,
        ST_NOT_SINGULAR = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        KIND_NULL   = 2'd0,
        KIND_FALSE  = 2'd1,
        KIND_TRUE   = 2'd2,
        KIND_NUMBER = 2'd3
    } kind_t;

    typedef struct packed {
        status_t status;
        kind_t   kind;
    } scan_result_t;

    localparam logic [2:0] LEN_TRUE  = 3'd4;
    localparam logic [2:0] LEN_FALSE = 3'd5;
    localparam logic [2:0] LEN_NULL  = 3'd4;

    function automatic logic is_ws(input logic [7:0] b);
        is_ws = (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        is_digit = (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_nonzero_digit(input logic [7:0] b);
        is_nonzero_digit = (b >= 8'h31) && (b <= 8'h39);
    endfunction

    function automatic logic [7:0] word_true(input logic [2:0] pos);
        unique case (pos)
            3'd0:    word_true = 8'h74;
            3'd1:    word_true = 8'h72;
            3'd2:    word_true = 8'h75;
            3'd3:    word_true = 8'h65;
            default: word_true = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] word_false(input logic [2:0] pos);
        unique case (pos)
            3'd0:    word_false = 8'h66;
            3'd1:    word_false = 8'h61;
            3'd2:    word_false = 8'h6C;
            3'd3:    word_false = 8'h73;
            3'd4:    word_false = 8'h65;
            default: word_false = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] word_null(input logic [2:0] pos);
        unique case (pos)
            3'd0:    word_null = 8'h6E;
            3'd1:    word_null = 8'h75;
            3'd2:    word_null = 8'h6C;
            3'd3:    word_null = 8'h6C;
            default: word_null = 8'h00;
        endcase
    endfunction

endpackage

`default_nettype wire

/* sv/json_scalar_validator_top.sv */
// Byte-serial checker for a JSON text whose root is a scalar (true, false, null or a number).
// Feed one character per item and close the text with an item that has end_of_text set; that
// item alone yields a result (parse_status, value_kind), after which the checker is back at
// its reset state for the next text. One item is taken per clock cycle: the character is
// latched in an input register and the scanner state is updated from it in the next cycle.
// The result enters an output register when the end marker leaves the input register, which
// happens once the output register is empty or its earlier result is being taken.
// Input stalls only when an end marker meets a result still waiting at the output.
`default_nettype none

module json_scalar_validator_top
    import jsv_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] text_byte,
    input  wire logic       end_of_text,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      parse_status,
    output logic [1:0]      value_kind
);

    logic         s1_valid_reg;
    logic         s1_valid_next;
    logic [7:0]   s1_byte_reg;
    logic         s1_eot_reg;
    logic         s1_fire;
    logic         in_fire;
    logic         out_valid_reg;
    logic         out_valid_next;
    scan_result_t out_data_reg;
    scan_result_t core_result;
    phase_t       core_phase;

    assign s1_fire  = s1_valid_reg && (!s1_eot_reg || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (s1_fire && s1_eot_reg)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the item until it advances
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg <= text_byte;
            s1_eot_reg  <= end_of_text;
        end
        if (s1_fire && s1_eot_reg)
            out_data_reg <= core_result;
    end

    jsv_scan_core u_scan_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (s1_fire),
        .text_byte   (s1_byte_reg),
        .end_of_text (s1_eot_reg),
        .result      (core_result),
        .phase       (core_phase)
    );

    assign out_valid    = out_valid_reg;
    assign parse_status = out_data_reg.status;
    assign value_kind   = out_data_reg.kind;

    a_kind_only_when_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (parse_status == ST_OK) || (value_kind == KIND_NULL))
        else $error("value kind set on a failed parse");

    a_restart_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_eot_reg) |=> (core_phase == PH_LEAD))
        else $error("scanner did not restart after end marker");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && s1_eot_reg && out_valid_reg && !out_ready))
        else $error("input stalled without a waiting result");

    a_result_from_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !$past(out_valid)) |-> $past(s1_fire && s1_eot_reg))
        else $error("result raised without an end marker");

endmodule

`default_nettype wire

/* sv/jsv_scan_core.sv */
`default_nettype none

module jsv_scan_core
    import jsv_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step_en,
    input  wire logic [7:0]   text_byte,
    input  wire logic         end_of_text,
    output scan_result_t      result,
    output phase_t            phase
);

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [2:0] pos_reg;
    logic [2:0] pos_next;
    status_t    status_reg;
    status_t    status_next;
    kind_t      kind_reg;
    kind_t      kind_next;

    logic [7:0] lit_char;
    logic [2:0] lit_len;
    kind_t      lit_kind;
    logic       lit_phase;
    logic [2:0] pos_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_LEAD;
            pos_reg    <= 3'd0;
            status_reg <= ST_OK;
            kind_reg   <= KIND_NULL;
        end
        else if (step_en)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            status_reg <= status_next;
            kind_reg   <= kind_next;
        end
    end

    always_comb
    begin
        lit_phase = 1'b1;
        unique case (phase_reg)
            PH_LIT_TRUE:
            begin
                lit_char = word_true(pos_reg);
                lit_len  = LEN_TRUE;
                lit_kind = KIND_TRUE;
            end
            PH_LIT_FALSE:
            begin
                lit_char = word_false(pos_reg);
                lit_len  = LEN_FALSE;
                lit_kind = KIND_FALSE;
            end
            PH_LIT_NULL:
            begin
                lit_char = word_null(pos_reg);
                lit_len  = LEN_NULL;
                lit_kind = KIND_NULL;
            end
            default:
            begin
                lit_char  = 8'h00;
                lit_len   = 3'd0;
                lit_kind  = KIND_NULL;
                lit_phase = 1'b0;
            end
        endcase
        pos_inc = pos_reg + 3'd1;
    end

    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        status_next = status_reg;
        kind_next   = kind_reg;
        result.kind = KIND_NULL;

        if (status_reg != ST_OK)
        begin
            result.status = status_reg;
        end
        else
        begin
            unique case (phase_reg)
                PH_LEAD:
                    result.status = ST_EXPECT;
                PH_ZERO, PH_INT, PH_FRAC, PH_EXP_DIG:
                begin
                    result.status = ST_OK;
                    result.kind   = KIND_NUMBER;
                end
                PH_TRAIL:
                begin
                    result.status = ST_OK;
                    result.kind   = kind_reg;
                end
                default:
                    result.status = ST_INVALID;
            endcase
        end

        if (end_of_text)
        begin
            phase_next  = PH_LEAD;
            pos_next    = 3'd0;
            status_next = ST_OK;
            kind_next   = KIND_NULL;
        end
        else if (lit_phase)
        begin
            if ((pos_reg >= lit_len) || (lit_char != text_byte))
            begin
                status_next = ST_INVALID;
                kind_next   = KIND_NULL;
                phase_next  = PH_ERROR;
            end
            else
            begin
                pos_next = pos_inc;
                if (pos_inc == lit_len)
                begin
                    kind_next  = lit_kind;
                    phase_next = PH_TRAIL;
                end
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_LEAD:
                begin
                    if (!is_ws(text_byte))
                    begin
                        pos_next = 3'd1;
                        priority if (text_byte == 8'h74)
                            phase_next = PH_LIT_TRUE;
                        else if (text_byte == 8'h66)
                            phase_next = PH_LIT_FALSE;
                        else if (text_byte == 8'h6E)
                            phase_next = PH_LIT_NULL;
                        else
                        begin
                            pos_next  = 3'd0;
                            kind_next = KIND_NUMBER;
                            priority if (text_byte == 8'h2D)
                                phase_next = PH_MINUS;
                            else if (text_byte == 8'h30)
                                phase_next = PH_ZERO;
                            else if (is_nonzero_digit(text_byte))
                                phase_next = PH_INT;
                            else
                            begin
                                status_next = ST_INVALID;
                                kind_next   = KIND_NULL;
                                phase_next  = PH_ERROR;
                            end
                        end
                    end
                end
                PH_MINUS:
                begin
                    priority if (text_byte == 8'h30)
                        phase_next = PH_ZERO;
                    else if (is_nonzero_digit(text_byte))
                        phase_next = PH_INT;
                    else
                    begin
                        status_next = ST_INVALID;
                        kind_next   = KIND_NULL;
                        phase_next  = PH_ERROR;
                    end
                end
                PH_ZERO, PH_INT, PH_FRAC:
                begin
                    priority if ((phase_reg != PH_ZERO) && is_digit(text_byte))
                        phase_next = phase_reg;
                    else if ((phase_reg != PH_FRAC) && (text_byte == 8'h2E))
                        phase_next = PH_DOT;
                    else if ((text_byte == 8'h65) || (text_byte == 8'h45))
                        phase_next = PH_EXP;
                    else if (is_ws(text_byte))
                        phase_next = PH_TRAIL;
                    else
                    begin
                        status_next = ST_NOT_SINGULAR;
                        kind_next   = KIND_NULL;
                        phase_next  = PH_ERROR;
                    end
                end
                PH_DOT, PH_EXP_SIGN:
                begin
                    if (is_digit(text_byte))
                        phase_next = (phase_reg == PH_DOT) ? PH_FRAC : PH_EXP_DIG;
                    else
                    begin
                        status_next = ST_INVALID;
                        kind_next   = KIND_NULL;
                        phase_next  = PH_ERROR;
                    end
                end
                PH_EXP:
                begin
                    priority if ((text_byte == 8'h2B) || (text_byte == 8'h2D))
                        phase_next = PH_EXP_SIGN;
                    else if (is_digit(text_byte))
                        phase_next = PH_EXP_DIG;
                    else
                    begin
                        status_next = ST_INVALID;
                        kind_next   = KIND_NULL;
                        phase_next  = PH_ERROR;
                    end
                end
                PH_EXP_DIG, PH_TRAIL:
                begin
                    priority if ((phase_reg == PH_EXP_DIG) && is_digit(text_byte))
                        phase_next = PH_EXP_DIG;
                    else if (is_ws(text_byte))
                        phase_next = PH_TRAIL;
                    else
                    begin
                        status_next = ST_NOT_SINGULAR;
                        kind_next   = KIND_NULL;
                        phase_next  = PH_ERROR;
                    end
                end
                default:
                    phase_next = phase_reg;
            endcase
        end
    end

    assign phase = phase_reg;

endmodule

`default_nettype wire
